// File: src/scaled_2d_convolution_top_defines.svh
// ---------------------------------------------------------------------------
// Scaled 2D convolution - assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef SCALED_2D_CONVOLUTION_TOP_DEFINES_SVH
`define SCALED_2D_CONVOLUTION_TOP_DEFINES_SVH

// same-cycle implication, reset masked
`define SCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define SCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/scd_pkg.sv
// ---------------------------------------------------------------------------
// Scaled 2D convolution - package
// Fixed field widths, register indexes and control structs.
// ---------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

  localparam int PIX_W      = 24;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int OUT_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ROW_W      = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RECIP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_OFFSET = 3'd4;

  // item modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_COEF  = 1'b1;

  // controls shared by all cells of the chain
  typedef struct packed {
    logic rd;     // read line column
    logic wr;     // write line column
    logic shift;  // shift window row
    logic clr;    // write zeros (clearing pass)
  } cell_ctl_t;

  // one tap request to the multiply-accumulate unit
  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } tap_req_t;

endpackage

`default_nettype wire

// File: src/scaled_2d_convolution_top.sv
// ---------------------------------------------------------------------------
// Scaled 2D convolution - top level
// Line buffers, window cells, tap sequencer, scaling and result register.
// ---------------------------------------------------------------------------
// Takes one item at a time. A coefficient item leaves the block ready for
// the next item. A pixel item that makes no result is read from the line
// buffer as it is taken, then shifted through the cell chain. A pixel item
// that makes a result also sends its taps one per cycle through the single
// shared multiply-accumulate unit, followed by a 5-stage scale, round,
// offset and saturate pipeline. After reset, a clearing pass over all
// MAX_LINE line buffer addresses zeroes the line buffers before the first
// item is taken; configuration writes are taken at any time. A finished
// result waits in the output register while the next item is accepted.
`default_nettype none

module scaled_2d_convolution_top #(
  parameter int MAX_K    = 7,
  parameter int MAX_LINE = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [scd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [scd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_mode,
  input  wire logic signed [scd_pkg::PIX_W-1:0]     in_pixel,
  input  wire logic                                 in_frame_start,
  input  wire logic [5:0]                           in_coeff_index,
  input  wire logic signed [scd_pkg::COEF_W-1:0]    in_coeff_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [scd_pkg::OUT_W-1:0]          out_result_value,
  output logic                                      out_row_end,
  output logic                                      out_saturated
);
  import scd_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE);
  localparam int KW_W  = $clog2(MAX_K + 1);
  localparam int KI_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int NTAP  = MAX_K * MAX_K;
  localparam int CI_W  = (NTAP > 1) ? $clog2(NTAP) : 1;
  localparam int ACC_W = PROD_W + $clog2(NTAP + 1);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [2:0]               kw_r, kh_r;
  logic [10:0]              lw_r;
  logic signed [31:0]       rr_r, off_r;
  logic [KW_W-1:0]          kw_e, kh_e;
  logic [31:0]              lw_e;
  logic [COL_W-1:0]         col_r, clr_cnt_r, addr_r;
  logic [ROW_W-1:0]         row_r;
  logic [COL_W-1:0]         c_now;
  logic [ROW_W-1:0]         r_now;
  logic                     last_now, emit_now;
  logic signed [PIX_W-1:0]  pix_r;
  logic                     last_r, emit_r;
  logic [KW_W-1:0]          ta_r, tb_r;
  logic [CI_W-1:0]          idx_r;
  logic                     in_acc, pix_acc, coef_acc, tap_end, out_load;
  cell_ctl_t                ctl;
  logic [COL_W-1:0]         cell_addr;
  logic [KI_W-1:0]          col_sel, row_sel;
  logic signed [PIX_W-1:0]  col_w  [MAX_K];
  logic signed [PIX_W-1:0]  cell_pix [MAX_K];
  tap_req_t                 tap;
  logic signed [ACC_W-1:0]  acc;
  logic                     mac_done, scl_done, scl_sat;
  logic signed [OUT_W-1:0]  scl_result;
  logic                     out_valid_r, out_row_end_r, out_sat_r;
  logic signed [OUT_W-1:0]  out_result_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_r  <= 3'd3;
      kh_r  <= 3'd3;
      lw_r  <= 11'd1024;
      rr_r  <= 32'sd65536;
      off_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_WIDTH:  kw_r  <= cfg_wdata[2:0];
        CFG_KERNEL_HEIGHT: kh_r  <= cfg_wdata[2:0];
        CFG_LINE_WIDTH:    lw_r  <= cfg_wdata[10:0];
        CFG_SCALE_RECIP:   rr_r  <= cfg_wdata;
        CFG_RESULT_OFFSET: off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp register values into range
  always_comb begin
    if (kw_r == 3'd0)          kw_e = KW_W'(1);
    else if (32'(kw_r) > MAX_K) kw_e = KW_W'(MAX_K);
    else                       kw_e = KW_W'(kw_r);
    if (kh_r == 3'd0)          kh_e = KW_W'(1);
    else if (32'(kh_r) > MAX_K) kh_e = KW_W'(MAX_K);
    else                       kh_e = KW_W'(kh_r);
    if (lw_r == 11'd0)               lw_e = 32'd1;
    else if (32'(lw_r) > MAX_LINE)   lw_e = 32'(MAX_LINE);
    else                             lw_e = 32'(lw_r);
  end

  assign in_acc   = in_valid && !in_stall;
  assign pix_acc  = in_acc && (in_mode == MODE_PIXEL);
  assign coef_acc = in_acc && (in_mode == MODE_COEF) && (32'(in_coeff_index) < NTAP);

  // position of the arriving pixel
  always_comb begin
    c_now = in_frame_start ? '0 : col_r;
    r_now = in_frame_start ? '0 : row_r;
    if (32'(c_now) >= MAX_LINE) c_now = '0;
    last_now = (32'(c_now) + 32'd1) >= lw_e;
    emit_now = ((32'(r_now) + 32'd1) >= 32'(kh_e)) && ((32'(c_now) + 32'd1) >= 32'(kw_e));
  end

  // counters and per-item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (pix_acc) begin
      if (last_now) begin
        col_r <= '0;
        row_r <= (r_now == '1) ? r_now : r_now + 1'b1;
      end else begin
        col_r <= COL_W'(32'(c_now) + 32'd1);
        row_r <= r_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      addr_r <= c_now;
      pix_r  <= in_pixel;
      last_r <= last_now;
      emit_r <= emit_now;
    end
  end

  // tap sequencer
  assign tap_end = (ta_r == kh_e - 1'b1) && (tb_r == kw_e - 1'b1);
  always_ff @(posedge clk) begin
    if (state_r == ST_SHIFT) begin
      ta_r  <= '0;
      tb_r  <= '0;
      idx_r <= '0;
    end else if (state_r == ST_MAC) begin
      idx_r <= idx_r + 1'b1;
      if (tb_r == kw_e - 1'b1) begin
        tb_r <= '0;
        ta_r <= ta_r + 1'b1;
      end else begin
        tb_r <= tb_r + 1'b1;
      end
    end
  end

  assign tap.issue = (state_r == ST_MAC);
  assign tap.first = (state_r == ST_MAC) && (idx_r == '0);
  assign tap.last  = (state_r == ST_MAC) && tap_end;
  assign row_sel   = KI_W'(kh_e - 1'b1 - ta_r);
  assign col_sel   = KI_W'((KW_W + 1)'(MAX_K) - (KW_W + 1)'(kw_e) + (KW_W + 1)'(tb_r));

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (state_r == ST_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // cell chain controls
  assign ctl.rd    = pix_acc;
  assign ctl.wr    = (state_r == ST_SHIFT) || (state_r == ST_CLR);
  assign ctl.shift = (state_r == ST_SHIFT);
  assign ctl.clr   = (state_r == ST_CLR);
  always_comb begin
    priority if (state_r == ST_CLR)  cell_addr = clr_cnt_r;
    else if (state_r == ST_IDLE)     cell_addr = c_now;
    else                             cell_addr = addr_r;
  end

  assign col_w[0] = pix_r;

  for (genvar k = 0; k < MAX_K; k++) begin : g_cell
    if (k < MAX_K - 1) begin : g_mid
      scd_cell #(.MAX_K(MAX_K), .MAX_LINE(MAX_LINE), .HAS_LINE(1'b1)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .addr    (cell_addr),
        .col_in  (col_w[k]),
        .col_sel (col_sel),
        .col_out (col_w[k+1]),
        .tap_pix (cell_pix[k])
      );
    end else begin : g_end
      scd_cell #(.MAX_K(MAX_K), .MAX_LINE(MAX_LINE), .HAS_LINE(1'b0)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .addr    (cell_addr),
        .col_in  (col_w[k]),
        .col_sel (col_sel),
        .col_out (),
        .tap_pix (cell_pix[k])
      );
    end
  end

  scd_mac #(.MAX_K(MAX_K)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef_we  (coef_acc),
    .coef_wa  (CI_W'(in_coeff_index)),
    .coef_wd  (in_coeff_value),
    .tap      (tap),
    .tap_addr (idx_r),
    .tap_pix  (cell_pix[row_sel]),
    .acc      (acc),
    .done     (mac_done)
  );

  scd_scale #(.ACC_W(ACC_W)) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mac_done),
    .sum    (acc),
    .rr     (rr_r),
    .off    (off_r),
    .done   (scl_done),
    .result (scl_result),
    .sat    (scl_sat)
  );

  // sequencer
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:   if (clr_cnt_r == COL_W'(MAX_LINE - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (pix_acc) state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = emit_r ? ST_MAC : ST_IDLE;
      ST_MAC:   if (tap_end) state_nxt = ST_WAIT;
      ST_WAIT:  if (scl_done) state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != ST_IDLE);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result_r  <= scl_result;
      out_sat_r     <= scl_sat;
      out_row_end_r <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_row_end      = out_row_end_r;
  assign out_saturated    = out_sat_r;

endmodule

`default_nettype wire

// File: src/scd_cell.sv
// ---------------------------------------------------------------------------
// Scaled 2D convolution - chain cell
// One line buffer row (when HAS_LINE is set) plus one window row; passes the old column value on.
// ---------------------------------------------------------------------------
`default_nettype none

module scd_cell #(
  parameter int MAX_K    = 7,
  parameter int MAX_LINE = 1024,
  parameter bit HAS_LINE = 1'b1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire scd_pkg::cell_ctl_t                ctl,
  input  wire logic [$clog2(MAX_LINE)-1:0]       addr,
  input  wire logic signed [scd_pkg::PIX_W-1:0]  col_in,
  input  wire logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0] col_sel,
  output logic signed [scd_pkg::PIX_W-1:0]       col_out,
  output logic signed [scd_pkg::PIX_W-1:0]       tap_pix
);
  import scd_pkg::*;

  logic signed [PIX_W-1:0] win_r [MAX_K];

  // line buffer row
  if (HAS_LINE) begin : g_line
    logic signed [PIX_W-1:0] mem [MAX_LINE];
    logic signed [PIX_W-1:0] rdq_r;

    always_ff @(posedge clk) begin
      if (ctl.wr) begin
        mem[addr] <= ctl.clr ? '0 : col_in;
      end
      if (ctl.rd) begin
        rdq_r <= mem[addr];
      end
    end
    assign col_out = rdq_r;
  end else begin : g_noline
    assign col_out = '0;
  end

  // window row, newest pixel at the top index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_K; j++) win_r[j] <= '0;
    end else if (ctl.shift) begin
      for (int j = 0; j < MAX_K - 1; j++) win_r[j] <= win_r[j+1];
      win_r[MAX_K-1] <= col_in;
    end
  end

  assign tap_pix = win_r[col_sel];

endmodule

`default_nettype wire

// File: src/scd_mac.sv
// ---------------------------------------------------------------------------
// Scaled 2D convolution - multiply-accumulate unit
// Coefficient store and one pipelined tap multiplier with accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module scd_mac #(
  parameter int MAX_K = 7
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 coef_we,
  input  wire logic [((MAX_K*MAX_K > 1) ? $clog2(MAX_K*MAX_K) : 1)-1:0] coef_wa,
  input  wire logic signed [scd_pkg::COEF_W-1:0]    coef_wd,
  input  wire scd_pkg::tap_req_t                    tap,
  input  wire logic [((MAX_K*MAX_K > 1) ? $clog2(MAX_K*MAX_K) : 1)-1:0] tap_addr,
  input  wire logic signed [scd_pkg::PIX_W-1:0]     tap_pix,
  output logic signed [scd_pkg::PROD_W+$clog2(MAX_K*MAX_K+1)-1:0] acc,
  output logic                                      done
);
  import scd_pkg::*;

  localparam int NTAP  = MAX_K * MAX_K;
  localparam int ACC_W = PROD_W + $clog2(NTAP + 1);

  logic signed [COEF_W-1:0] mem [NTAP];
  logic [NTAP-1:0]          vld_r;
  logic signed [COEF_W-1:0] memq_r;
  logic                     vldq_r;
  logic signed [PIX_W-1:0]  pixq_r;
  logic                     v1_r, f1_r, l1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     v2_r, f2_r, l2_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     done_r;
  logic signed [COEF_W-1:0] coef;

  // coefficient store, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (coef_we) begin
      mem[coef_wa] <= coef_wd;
    end
    if (tap.issue) begin
      memq_r <= mem[tap_addr];
      pixq_r <= tap_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vldq_r <= 1'b0;
    end else begin
      if (coef_we) vld_r[coef_wa] <= 1'b1;
      if (tap.issue) vldq_r <= vld_r[tap_addr];
    end
  end

  assign coef = vldq_r ? memq_r : '0;

  // product stage
  always_ff @(posedge clk) begin
    if (v1_r) prod_r <= pixq_r * coef;
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= (f2_r ? '0 : acc_r) + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      f1_r   <= 1'b0;
      l1_r   <= 1'b0;
      v2_r   <= 1'b0;
      f2_r   <= 1'b0;
      l2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= tap.issue;
      f1_r   <= tap.first;
      l1_r   <= tap.last;
      v2_r   <= v1_r;
      f2_r   <= f1_r;
      l2_r   <= l1_r;
      done_r <= v2_r && l2_r;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

// File: src/scd_scale.sv
// ---------------------------------------------------------------------------
// Scaled 2D convolution - scale and offset
// Sum times reciprocal, rounded shift by 16, offset, 40-bit saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module scd_scale #(
  parameter int ACC_W = 46
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [ACC_W-1:0]            sum,
  input  wire logic signed [31:0]                 rr,
  input  wire logic signed [31:0]                 off,
  output logic                                    done,
  output logic signed [scd_pkg::OUT_W-1:0]        result,
  output logic                                    sat
);
  import scd_pkg::*;

  localparam int LO_W  = 22;
  localparam int HI_W  = ACC_W - LO_W;
  localparam int A_W   = HI_W + 32;
  localparam int B_W   = LO_W + 32 + 1;
  localparam int Q_W   = A_W + 6 + 1;
  localparam int VAL_W = Q_W + 2;

  logic [ACC_W-1:0]        ms_r;
  logic [31:0]             mr_r;
  logic                    neg_r;
  logic [A_W-1:0]          a_r;
  logic [B_W-1:0]          b_r;
  logic [Q_W-1:0]          q_r;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] mag;
  logic signed [OUT_W-1:0] result_r;
  logic                    sat_r;
  logic [4:0]              v_r;
  logic                    fits;

  // magnitudes and sign
  always_ff @(posedge clk) begin
    if (start) begin
      ms_r  <= sum[ACC_W-1] ? (~sum + 1'b1) : sum;
      mr_r  <= rr[31] ? (~rr + 1'b1) : rr;
      neg_r <= sum[ACC_W-1] ^ rr[31];
    end
  end

  // split product, low half carries the rounding constant
  always_ff @(posedge clk) begin
    if (v_r[0]) begin
      a_r <= A_W'(ms_r[ACC_W-1:LO_W]) * A_W'(mr_r);
      b_r <= B_W'(ms_r[LO_W-1:0]) * B_W'(mr_r) + B_W'(32'h8000);
    end
  end

  always_ff @(posedge clk) begin
    if (v_r[1]) q_r <= (Q_W'(a_r) << 6) + Q_W'(b_r[B_W-1:16]);
  end

  // apply sign and offset
  assign mag = {2'b00, q_r};
  always_ff @(posedge clk) begin
    if (v_r[2]) begin
      val_r <= (neg_r ? -mag : mag) + {{(VAL_W-32){off[31]}}, off};
    end
  end

  // saturate to 40 bits
  assign fits = (val_r[VAL_W-1:OUT_W-1] == '0) || (val_r[VAL_W-1:OUT_W-1] == '1);
  always_ff @(posedge clk) begin
    if (v_r[3]) begin
      sat_r <= !fits;
      if (fits) begin
        result_r <= val_r[OUT_W-1:0];
      end else begin
        result_r <= val_r[VAL_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], start};
    end
  end

  assign done   = v_r[4];
  assign result = result_r;
  assign sat    = sat_r;

endmodule

`default_nettype wire

// File: src/scd_checker.sv
// ---------------------------------------------------------------------------
// Scaled 2D convolution - port checker
// Watches the top level ports; bound to the top level below.
// ---------------------------------------------------------------------------
`default_nettype none

`include "scaled_2d_convolution_top_defines.svh"

module scd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          in_mode,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [39:0]            out_result_value,
  input wire logic                          out_row_end,
  input wire logic                          out_saturated
);

  // stalled result stays offered
  `SCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // stalled result payload holds
  `SCD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_result_value) && $stable(out_row_end) && $stable(out_saturated), "result changed while stalled")

  // a taken pixel item sets the block busy, raising in_stall
  `SCD_ASSERT_NEXT(a_pix_busy, in_valid && !in_stall && !in_mode, in_stall, "pixel item not followed by busy cycle")

  // a clipped result sits at one end of the range
  `SCD_ASSERT_NOW(a_sat_ends, out_valid && out_saturated, out_result_value == 40'sh7F_FFFF_FFFF || out_result_value == -40'sh80_0000_0000, "saturated result not at range end")

endmodule

bind scaled_2d_convolution_top scd_checker u_scd_checker (.*);

`default_nettype wire
